[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with an active-low asynchronous reset as the disable term.
`define ASSERT_CLKED(name, clock, reset_n, prop, msg) \
    name: assert property (@(posedge clock) disable iff (!reset_n) prop) else $error(msg);

// Overlapping implication built on the clocked form.
`define ASSERT_IMPLY(name, clock, reset_n, ante, cons, msg) \
    `ASSERT_CLKED(name, clock, reset_n, (ante) |-> (cons), msg)

`endif

[hw/rtl/sgis_pkg.sv]
// ----------------------------------------------------------------------------
// sgis_pkg
// Types, constants and control encodings of the sorted grid interval search.
// ----------------------------------------------------------------------------
`default_nettype none

package sgis_pkg;

    localparam int GRID_DEPTH = 64;
    localparam int ADDR_W     = $clog2(GRID_DEPTH);
    localparam int SIZE_W     = 7;
    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int WGT_W      = 17;
    localparam int POS_W      = 8;
    localparam int DIV_CNT_W  = $clog2(FRAC_W);

    localparam logic [WGT_W-1:0] WEIGHT_ONE = WGT_W'(1) << FRAC_W;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_INTERP = 2'd1;
    localparam logic [1:0] REQ_BIN    = 2'd2;

    localparam logic CFG_IDX_GRID_SIZE = 1'b0;

    typedef struct packed {
        logic [1:0]               req_type;
        logic [ADDR_W-1:0]        entry_index;
        logic signed [DATA_W-1:0] data_word;
    } req_t;

    typedef struct packed {
        logic                    status;
        logic signed [POS_W-1:0] position;
        logic [WGT_W-1:0]        weight_upper;
        logic [WGT_W-1:0]        weight_lower;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_CHK_FIRST,
        S_CHK_LAST,
        S_SRCH,
        S_SRCH_CMP,
        S_RD_CUR,
        S_CHK_CUR,
        S_GET_PREV,
        S_DIV_CHK,
        S_DIV,
        S_DIV_DONE
    } state_t;

    typedef enum logic [2:0] {
        RD_FIRST,
        RD_LAST,
        RD_MID,
        RD_CUR,
        RD_PREV
    } rd_sel_t;

    typedef enum logic [2:0] {
        RES_TOO_FEW,
        RES_BELOW,
        RES_ABOVE,
        RES_BIN,
        RES_EXACT,
        RES_ZERO,
        RES_ONE,
        RES_DIV
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     mem_wr;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     srch_init;
        logic     mid_load;
        logic     srch_step;
        logic     set_i;
        logic     load_x1;
        logic     load_x0;
        logic     div_step;
        logic     res_load;
        res_sel_t res_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic too_few;
        logic is_bin;
        logic x_le_rd;
        logic x_ge_rd;
        logic x_eq_rd;
        logic cnt_zero;
        logic num_le0;
        logic sat_one;
        logic div_last;
    } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/sorted_grid_interval_search_unit.sv]
// ----------------------------------------------------------------------------
// sorted_grid_interval_search_unit
// Position lookup of a Q16.16 value within a sorted grid of up to 64 points.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A grid write raises no
// busy time. A query walks the grid through a single registered memory read
// port: two range checks, a binary search over the active points, and for an
// interpolation inside the grid two more reads and a bit-serial divider that
// yields one weight bit a cycle. Each result is shown for one cycle under done
// and the receiver must take it then; busy is already low in that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_grid_interval_search_unit
    import sgis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        req_data,
    output logic        done,
    output rsp_t        rsp_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [SIZE_W-1:0] grid_size_reg;
    logic              cfg_wr;
    dp_cmd_t           cmd;
    dp_stat_t          stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_GRID_SIZE);
    assign prdata = (paddr[2] == CFG_IDX_GRID_SIZE) ? 32'(grid_size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= SIZE_W'(2);
        end
        else if (cfg_wr)
        begin
            grid_size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    sgis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_data.req_type),
        .stat     (stat),
        .busy     (busy),
        .cmd      (cmd)
    );

    sgis_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req_data  (req_data),
        .grid_size (grid_size_reg),
        .stat      (stat),
        .done      (done),
        .rsp_data  (rsp_data)
    );

endmodule

`default_nettype wire

[hw/rtl/sgis_datapath.sv]
// ----------------------------------------------------------------------------
// sgis_datapath
// Grid memory, binary search registers, serial divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgis_datapath
    import sgis_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    input  req_t              req_data,
    input  logic [SIZE_W-1:0] grid_size,
    output dp_stat_t          stat,
    output logic              done,
    output rsp_t              rsp_data
);

    logic signed [DATA_W-1:0] mem_reg [GRID_DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] x1_reg;
    logic                     bin_reg;
    logic [SIZE_W-1:0]        n_reg;
    logic [SIZE_W-1:0]        lo_reg;
    logic [SIZE_W-1:0]        lo_next;
    logic [SIZE_W-1:0]        cnt_reg;
    logic [SIZE_W-1:0]        cnt_next;
    logic [SIZE_W-1:0]        mid_reg;
    logic [ADDR_W-1:0]        i_reg;
    logic [ADDR_W-1:0]        i_next;
    logic signed [DATA_W:0]   num_reg;
    logic signed [DATA_W:0]   num_next;
    logic signed [DATA_W:0]   den_reg;
    logic signed [DATA_W:0]   den_next;
    logic [DATA_W:0]          rem_reg;
    logic [DATA_W:0]          rem_next;
    logic [FRAC_W-1:0]        q_reg;
    logic [FRAC_W-1:0]        q_next;
    logic [DIV_CNT_W-1:0]     div_cnt_reg;
    logic                     done_reg;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;

    logic [SIZE_W-1:0]        n_clamp;
    logic [SIZE_W-1:0]        half;
    logic [SIZE_W-1:0]        mid_calc;
    logic [SIZE_W-1:0]        n_last;
    logic [ADDR_W-1:0]        rd_addr;
    logic [DATA_W+1:0]        trial;
    logic [DATA_W+1:0]        den_wide;
    logic [POS_W-1:0]         pos_n;
    logic [POS_W-1:0]         pos_i;

    assign n_clamp  = (grid_size > SIZE_W'(GRID_DEPTH)) ? SIZE_W'(GRID_DEPTH) : grid_size;
    assign half     = cnt_reg >> 1;
    assign mid_calc = lo_reg + half;
    assign n_last   = n_reg - SIZE_W'(1);
    assign pos_n    = POS_W'(n_reg);
    assign pos_i    = POS_W'(i_reg);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_FIRST: rd_addr = '0;
            RD_LAST:  rd_addr = n_last[ADDR_W-1:0];
            RD_MID:   rd_addr = mid_calc[ADDR_W-1:0];
            RD_CUR:   rd_addr = i_reg;
            RD_PREV:  rd_addr = i_reg - ADDR_W'(1);
            default:  rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem_reg[req_data.entry_index] <= req_data.data_word;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem_reg[rd_addr];
        end
    end

    always_comb
    begin
        if (cmd.srch_init)
        begin
            lo_next  = '0;
            cnt_next = n_reg;
        end
        else if (cmd.srch_step && (rdata_reg < x_reg))
        begin
            lo_next  = mid_reg + SIZE_W'(1);
            cnt_next = cnt_reg - half - SIZE_W'(1);
        end
        else if (cmd.srch_step)
        begin
            lo_next  = lo_reg;
            cnt_next = half;
        end
        else
        begin
            lo_next  = lo_reg;
            cnt_next = cnt_reg;
        end
    end

    always_comb
    begin
        if (lo_reg < SIZE_W'(1))
        begin
            i_next = ADDR_W'(1);
        end
        else if (lo_reg > n_last)
        begin
            i_next = n_last[ADDR_W-1:0];
        end
        else
        begin
            i_next = lo_reg[ADDR_W-1:0];
        end
    end

    assign num_next = {x_reg[DATA_W-1], x_reg} - {rdata_reg[DATA_W-1], rdata_reg};
    assign den_next = {x1_reg[DATA_W-1], x1_reg} - {rdata_reg[DATA_W-1], rdata_reg};

    assign trial    = {rem_reg, 1'b0};
    assign den_wide = {1'b0, den_reg};

    always_comb
    begin
        if (cmd.load_x0)
        begin
            rem_next = num_next;
            q_next   = '0;
        end
        else if (cmd.div_step && (trial >= den_wide))
        begin
            rem_next = (DATA_W+1)'(trial - den_wide);
            q_next   = {q_reg[FRAC_W-2:0], 1'b1};
        end
        else if (cmd.div_step)
        begin
            rem_next = trial[DATA_W:0];
            q_next   = {q_reg[FRAC_W-2:0], 1'b0};
        end
        else
        begin
            rem_next = rem_reg;
            q_next   = q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= req_data.data_word;
            bin_reg <= (req_data.req_type == REQ_BIN);
            n_reg   <= n_clamp;
        end
        if (cmd.mid_load)
        begin
            mid_reg <= mid_calc;
        end
        if (cmd.set_i)
        begin
            i_reg <= i_next;
        end
        if (cmd.load_x1)
        begin
            x1_reg <= rdata_reg;
        end
        if (cmd.load_x0)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
        lo_reg  <= lo_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (cmd.res_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load_x0)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            done_reg <= cmd.res_load;
        end
    end

    always_comb
    begin
        rsp_next = '0;
        case (cmd.res_sel)
            RES_TOO_FEW:
            begin
                rsp_next.status = 1'b1;
            end
            RES_BELOW:
            begin
                if (bin_reg)
                begin
                    rsp_next.position = '1;
                end
                else
                begin
                    rsp_next.weight_lower = WEIGHT_ONE;
                end
            end
            RES_ABOVE:
            begin
                if (bin_reg)
                begin
                    rsp_next.position = pos_n;
                end
                else
                begin
                    rsp_next.position     = pos_n - POS_W'(2);
                    rsp_next.weight_upper = WEIGHT_ONE;
                end
            end
            RES_BIN:
            begin
                rsp_next.position = POS_W'(lo_reg) - POS_W'(1);
            end
            RES_EXACT:
            begin
                rsp_next.position     = pos_i;
                rsp_next.weight_lower = WEIGHT_ONE;
            end
            RES_ZERO:
            begin
                rsp_next.position     = pos_i - POS_W'(1);
                rsp_next.weight_lower = WEIGHT_ONE;
            end
            RES_ONE:
            begin
                rsp_next.position     = pos_i - POS_W'(1);
                rsp_next.weight_upper = WEIGHT_ONE;
            end
            RES_DIV:
            begin
                rsp_next.position     = pos_i - POS_W'(1);
                rsp_next.weight_upper = WGT_W'(q_reg);
                rsp_next.weight_lower = WEIGHT_ONE - WGT_W'(q_reg);
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    always_comb
    begin
        stat.too_few  = (n_reg < SIZE_W'(2));
        stat.is_bin   = bin_reg;
        stat.x_le_rd  = (x_reg <= rdata_reg);
        stat.x_ge_rd  = (x_reg >= rdata_reg);
        stat.x_eq_rd  = (x_reg == rdata_reg);
        stat.cnt_zero = (cnt_reg == '0);
        stat.num_le0  = (num_reg <= 0);
        stat.sat_one  = (den_reg <= 0) || (num_reg >= den_reg);
        stat.div_last = (div_cnt_reg == DIV_CNT_W'(FRAC_W - 1));
    end

    assign done     = done_reg;
    assign rsp_data = rsp_reg;

endmodule

`default_nettype wire

[hw/rtl/sgis_ctrl.sv]
// ----------------------------------------------------------------------------
// sgis_ctrl
// Sequencer for range checks, binary search, interval fetch and division.
// ----------------------------------------------------------------------------
`default_nettype none

module sgis_ctrl
    import sgis_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] req_type,
    input  dp_stat_t   stat,
    output logic       busy,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   is_query;

    assign is_query = req_type inside {REQ_INTERP, REQ_BIN};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && is_query)
                begin
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                state_next = stat.too_few ? S_IDLE : S_CHK_FIRST;
            end
            S_CHK_FIRST:
            begin
                state_next = stat.x_le_rd ? S_IDLE : S_CHK_LAST;
            end
            S_CHK_LAST:
            begin
                state_next = stat.x_ge_rd ? S_IDLE : S_SRCH;
            end
            S_SRCH:
            begin
                if (!stat.cnt_zero)
                begin
                    state_next = S_SRCH_CMP;
                end
                else if (stat.is_bin)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RD_CUR;
                end
            end
            S_SRCH_CMP:
            begin
                state_next = S_SRCH;
            end
            S_RD_CUR:
            begin
                state_next = S_CHK_CUR;
            end
            S_CHK_CUR:
            begin
                state_next = stat.x_eq_rd ? S_IDLE : S_GET_PREV;
            end
            S_GET_PREV:
            begin
                state_next = S_DIV_CHK;
            end
            S_DIV_CHK:
            begin
                state_next = (stat.num_le0 || stat.sat_one) ? S_IDLE : S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = S_DIV_DONE;
                end
            end
            S_DIV_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.mem_wr = start && (req_type == REQ_WRITE);
                cmd.load   = start && is_query;
            end
            S_FIRST:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_FIRST;
                cmd.res_sel = RES_TOO_FEW;
                cmd.res_load = stat.too_few;
            end
            S_CHK_FIRST:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = RD_LAST;
                cmd.res_sel  = RES_BELOW;
                cmd.res_load = stat.x_le_rd;
            end
            S_CHK_LAST:
            begin
                cmd.res_sel   = RES_ABOVE;
                cmd.res_load  = stat.x_ge_rd;
                cmd.srch_init = !stat.x_ge_rd;
            end
            S_SRCH:
            begin
                cmd.rd_en    = !stat.cnt_zero;
                cmd.rd_sel   = RD_MID;
                cmd.mid_load = !stat.cnt_zero;
                cmd.res_sel  = RES_BIN;
                cmd.res_load = stat.cnt_zero && stat.is_bin;
                cmd.set_i    = stat.cnt_zero && !stat.is_bin;
            end
            S_SRCH_CMP:
            begin
                cmd.srch_step = 1'b1;
            end
            S_RD_CUR:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CUR;
            end
            S_CHK_CUR:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = RD_PREV;
                cmd.load_x1  = 1'b1;
                cmd.res_sel  = RES_EXACT;
                cmd.res_load = stat.x_eq_rd;
            end
            S_GET_PREV:
            begin
                cmd.load_x0 = 1'b1;
            end
            S_DIV_CHK:
            begin
                cmd.res_sel  = stat.num_le0 ? RES_ZERO : RES_ONE;
                cmd.res_load = stat.num_le0 || stat.sat_one;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_DIV_DONE:
            begin
                cmd.res_sel  = RES_DIV;
                cmd.res_load = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/sgis_checker.sv]
// ----------------------------------------------------------------------------
// sgis_checker
// Port-level checks of the interval search unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sgis_checker
    import sgis_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input req_t req_data,
    input logic done,
    input rsp_t rsp_data
);

    `ASSERT_IMPLY(a_done_idle, clk, rst_n, done, !busy && $past(busy), "result outside idle")
    `ASSERT_IMPLY(a_write_silent, clk, rst_n, start && !busy && (req_data.req_type == REQ_WRITE), ##1 !done, "write gave a result")
    `ASSERT_IMPLY(a_too_few, clk, rst_n, done && rsp_data.status, (rsp_data.position == 0) && (rsp_data.weight_upper == 0) && (rsp_data.weight_lower == 0), "bad error result")
    `ASSERT_IMPLY(a_weight_sum, clk, rst_n, done && !rsp_data.status, ((18'(rsp_data.weight_upper) + 18'(rsp_data.weight_lower)) == 18'(WEIGHT_ONE)) || ((rsp_data.weight_upper == 0) && (rsp_data.weight_lower == 0)), "weights do not sum")

endmodule

bind sorted_grid_interval_search_unit sgis_checker u_sgis_checker (.*);

`default_nettype wire

[test/sorted_grid_interval_search_unit_tb.sv]
// ----------------------------------------------------------------------------
// sorted_grid_interval_search_unit_tb
// Self-checking bench for the sorted grid interval search unit. A directed
// table covers reset size, range ends, exact hits, too few points and ignored
// requests. Random phases then load sorted, duplicated or unsorted grids under
// varying grid sizes and query them. Every result is checked against a table value or a bench prediction.
// ----------------------------------------------------------------------------
module sorted_grid_interval_search_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sgis_pkg::*;

    localparam logic [1:0]        REQ_IGNORED   = 2'd3;
    localparam int                SETTLE_CYCLES = 48;
    localparam int                STALL_LIMIT   = 2000;
    localparam int                RANDOM_ITEMS  = 850;
    localparam logic [DATA_W-1:0] Q_MIN         = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_MAX         = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_ONE         = 32'h0001_0000;
    localparam logic [DATA_W-1:0] Q_MINUS_ONE   = 32'hFFFF_0000;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        req_t              req;
        bit                typed;
        rsp_t              want;
        logic [SIZE_W-1:0] size;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req_data;
    logic        done;
    rsp_t        rsp_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic signed [DATA_W-1:0] grid_mirror [GRID_DEPTH];
    logic [SIZE_W-1:0]        size_mirror;
    rsp_t                     pending_lookups [$];
    stim_row_t                directed_rows [$];
    int                       mismatch_count;
    int                       rand_items;
    int                       stall_cycles = 0;
    bit                       steady;

    sorted_grid_interval_search_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req_data (req_data),
        .done     (done),
        .rsp_data (rsp_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    function automatic int first_not_below(int n, longint x);
        int lo;
        int cnt;
        int half;
        lo  = 0;
        cnt = n;
        while (cnt > 0)
        begin
            half = cnt / 2;
            if (longint'(grid_mirror[lo + half]) < x)
            begin
                lo  = lo + half + 1;
                cnt = cnt - half - 1;
            end
            else
            begin
                cnt = half;
            end
        end
        return lo;
    endfunction

    function automatic rsp_t predict_lookup(req_t r);
        rsp_t   res;
        int     n;
        int     i;
        longint x;
        longint x0;
        longint x1;
        longint wu;
        res = '0;
        n   = (size_mirror > GRID_DEPTH) ? GRID_DEPTH : int'(size_mirror);
        x   = longint'(r.data_word);
        wu  = 0;
        if (n < 2)
        begin
            res.status = 1'b1;
        end
        else if (r.req_type == REQ_INTERP)
        begin
            if (x <= longint'(grid_mirror[0]))
            begin
                res.position = '0;
            end
            else if (x >= longint'(grid_mirror[n-1]))
            begin
                res.position = POS_W'(n - 2);
                wu = longint'(WEIGHT_ONE);
            end
            else
            begin
                i = first_not_below(n, x);
                if (i < 1)
                    i = 1;
                if (i > n - 1)
                    i = n - 1;
                if (longint'(grid_mirror[i]) == x)
                begin
                    res.position = POS_W'(i);
                end
                else
                begin
                    res.position = POS_W'(i - 1);
                    x0 = longint'(grid_mirror[i-1]);
                    x1 = longint'(grid_mirror[i]);
                    if (x - x0 <= 0)
                        wu = 0;
                    else if (x1 - x0 <= 0 || x - x0 >= x1 - x0)
                        wu = longint'(WEIGHT_ONE);
                    else
                        wu = ((x - x0) << FRAC_W) / (x1 - x0);
                    if (wu > longint'(WEIGHT_ONE))
                        wu = longint'(WEIGHT_ONE);
                end
            end
            res.weight_upper = WGT_W'(wu);
            res.weight_lower = WEIGHT_ONE - WGT_W'(wu);
        end
        else
        begin
            if (x <= longint'(grid_mirror[0]))
                res.position = -8'sd1;
            else if (x >= longint'(grid_mirror[n-1]))
                res.position = POS_W'(n);
            else
                res.position = POS_W'(first_not_below(n, x) - 1);
        end
        return res;
    endfunction

    function automatic void dir_req(logic [1:0] kind, logic [ADDR_W-1:0] idx,
                                    logic [DATA_W-1:0] x);
        stim_row_t row;
        row.kind              = ROW_REQ;
        row.req.req_type      = kind;
        row.req.entry_index   = idx;
        row.req.data_word     = x;
        row.typed             = 1'b0;
        row.want              = '0;
        row.size              = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void dir_chk(logic [1:0] kind, logic [DATA_W-1:0] x, logic st,
                                    logic signed [POS_W-1:0] pos, logic [WGT_W-1:0] wu,
                                    logic [WGT_W-1:0] wl);
        stim_row_t row;
        row.kind              = ROW_REQ;
        row.req.req_type      = kind;
        row.req.entry_index   = '0;
        row.req.data_word     = x;
        row.typed             = 1'b1;
        row.want.status       = st;
        row.want.position     = pos;
        row.want.weight_upper = wu;
        row.want.weight_lower = wl;
        row.size              = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void dir_cfg(logic [SIZE_W-1:0] sz);
        stim_row_t row;
        row.kind  = ROW_CFG;
        row.req   = '0;
        row.typed = 1'b0;
        row.want  = '0;
        row.size  = sz;
        directed_rows.push_back(row);
    endfunction

    task automatic send_req(req_t r, bit typed, rsp_t typed_rsp);
        if (!steady)
        begin
            while ($urandom_range(0, 99) < 28)
            begin
                start = 1'b0;
                @(negedge clk);
            end
        end
        start    = 1'b1;
        req_data = r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (r.req_type)
            REQ_WRITE:
                grid_mirror[r.entry_index] = r.data_word;
            REQ_INTERP, REQ_BIN:
                pending_lookups.push_back(typed ? typed_rsp : predict_lookup(r));
            default:
                ;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_quiet();
        start = 1'b0;
        while (pending_lookups.size() != 0 || busy)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic set_grid_size(logic [SIZE_W-1:0] sz);
        wait_quiet();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 3'(CFG_IDX_GRID_SIZE) << 2;
        pwdata  = 32'(sz);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        size_mirror = sz;
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[SIZE_W-1:0] !== size_mirror)
            note_mismatch("grid_size readback", 64'(prdata), 64'(size_mirror));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_lookups.size() == 0)
            begin
                note_mismatch("result with nothing pending", 64'(rsp_data), '0);
            end
            else
            begin
                want = pending_lookups.pop_front();
                if (rsp_data.status !== want.status)
                    note_mismatch("status", 64'(rsp_data.status), 64'(want.status));
                if (rsp_data.position !== want.position)
                    note_mismatch("position", 64'(rsp_data.position), 64'(want.position));
                if (rsp_data.weight_upper !== want.weight_upper)
                    note_mismatch("weight_upper", 64'(rsp_data.weight_upper),
                                  64'(want.weight_upper));
                if (rsp_data.weight_lower !== want.weight_lower)
                    note_mismatch("weight_lower", 64'(rsp_data.weight_lower),
                                  64'(want.weight_lower));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        req_t              r;
        stim_row_t         row;
        int                vals [$];
        int                k;
        int                fill;
        int                mode;
        int                pick;
        int                n_act;
        int                phase;
        logic [SIZE_W-1:0] sz;
        longint            v;
        longint            lo;
        longint            hi;

        rst_n          = 1'b0;
        start          = 1'b0;
        req_data       = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        size_mirror    = 7'd2;
        mismatch_count = 0;
        rand_items     = 0;
        steady         = 1'b0;
        foreach (grid_mirror[j])
            grid_mirror[j] = '0;

        dir_req(REQ_WRITE, 6'd0, Q_MIN);
        dir_req(REQ_WRITE, 6'd1, Q_MINUS_ONE);
        dir_req(REQ_WRITE, 6'd2, '0);
        dir_req(REQ_WRITE, 6'd3, Q_ONE);
        dir_req(REQ_WRITE, 6'd63, Q_MAX);
        dir_chk(REQ_INTERP, Q_MIN, 1'b0, 8'sd0, '0, WEIGHT_ONE);
        dir_chk(REQ_BIN, Q_MAX, 1'b0, 8'sd2, '0, '0);
        dir_cfg(7'd0);
        dir_chk(REQ_INTERP, '0, 1'b1, 8'sd0, '0, '0);
        dir_chk(REQ_BIN, '0, 1'b1, 8'sd0, '0, '0);
        dir_cfg(7'd1);
        dir_chk(REQ_INTERP, Q_ONE, 1'b1, 8'sd0, '0, '0);
        dir_cfg(7'd4);
        dir_chk(REQ_INTERP, Q_MIN, 1'b0, 8'sd0, '0, WEIGHT_ONE);
        dir_chk(REQ_INTERP, Q_ONE, 1'b0, 8'sd2, WEIGHT_ONE, '0);
        dir_chk(REQ_INTERP, Q_MAX, 1'b0, 8'sd2, WEIGHT_ONE, '0);
        dir_chk(REQ_INTERP, '0, 1'b0, 8'sd2, '0, WEIGHT_ONE);
        dir_req(REQ_INTERP, 6'd0, 32'h0000_8000);
        dir_req(REQ_INTERP, 6'd0, 32'hFFFF_8000);
        dir_req(REQ_INTERP, 6'd0, Q_MINUS_ONE);
        dir_chk(REQ_BIN, Q_MIN, 1'b0, -8'sd1, '0, '0);
        dir_chk(REQ_BIN, Q_MAX, 1'b0, 8'sd4, '0, '0);
        dir_req(REQ_BIN, 6'd0, '0);
        dir_req(REQ_BIN, 6'd0, Q_MINUS_ONE);
        dir_req(REQ_IGNORED, 6'd5, 32'h1234_5678);

        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[j])
        begin
            row = directed_rows[j];
            if (row.kind == ROW_CFG)
                set_grid_size(row.size);
            else
                send_req(row.req, row.typed, row.want);
        end

        phase = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       sz = SIZE_W'($urandom_range(0, 1));
                1:       sz = 7'd64;
                2:       sz = $urandom_range(0, 1) ? 7'd127 : SIZE_W'($urandom_range(65, 127));
                3:       sz = 7'd2;
                default: sz = SIZE_W'($urandom_range(3, 64));
            endcase
            set_grid_size(sz);
            n_act = (sz > GRID_DEPTH) ? GRID_DEPTH : int'(sz);

            // The first phase writes every slot so that no later query sees an empty one.
            if (phase == 0 || n_act == GRID_DEPTH)
                fill = GRID_DEPTH;
            else
                fill = (n_act < 2) ? 3 : n_act;
            mode = $urandom_range(0, 9);
            vals.delete();
            if (mode < 4)
            begin
                repeat (fill)
                    vals.push_back(int'($urandom));
                vals.sort();
                if ($urandom_range(0, 1))
                begin
                    vals[0]      = int'(Q_MIN);
                    vals[fill-1] = int'(Q_MAX);
                end
            end
            else if (mode < 9)
            begin
                v = longint'($urandom_range(0, 32'h7FFF_FFFF)) - 64'sh4000_0000;
                repeat (fill)
                begin
                    vals.push_back(int'(v));
                    if (mode == 8 && $urandom_range(0, 2) == 0)
                        v = v;
                    else
                        v = v + longint'($urandom_range(1, 1 << $urandom_range(0, 20)));
                end
            end
            else
            begin
                repeat (fill)
                    vals.push_back(int'($urandom));
            end
            for (k = 0; k < fill; k++)
            begin
                r.req_type    = REQ_WRITE;
                r.entry_index = ADDR_W'(k);
                r.data_word   = vals[k];
                send_req(r, 1'b0, '0);
                rand_items++;
            end

            repeat ($urandom_range(15, 40))
            begin
                steady        = (rand_items >= 300 && rand_items < 450);
                pick          = $urandom_range(0, 99);
                r.entry_index = ADDR_W'($urandom);
                r.data_word   = $urandom;
                if (pick < 5)
                begin
                    r.req_type = REQ_WRITE;
                end
                else if (pick < 8)
                begin
                    r.req_type = REQ_IGNORED;
                end
                else
                begin
                    r.req_type = (pick < 54) ? REQ_INTERP : REQ_BIN;
                    if (n_act >= 2)
                    begin
                        k = $urandom_range(0, n_act - 1);
                        case ($urandom_range(0, 5))
                            0:
                                r.data_word = grid_mirror[k];
                            1:
                                r.data_word = grid_mirror[k] + ($urandom_range(0, 1) ? 1 : -1);
                            2, 3:
                            begin
                                if (k < n_act - 1)
                                begin
                                    lo = longint'(grid_mirror[k]);
                                    hi = longint'(grid_mirror[k+1]);
                                    if (hi > lo)
                                        r.data_word = DATA_W'(lo + longint'($urandom) % (hi - lo));
                                end
                            end
                            4:
                                r.data_word = $urandom_range(0, 1) ? Q_MIN : Q_MAX;
                            default:
                                ;
                        endcase
                    end
                end
                send_req(r, 1'b0, '0);
                if (r.req_type != REQ_IGNORED)
                    rand_items++;
            end
            steady = 1'b0;
            phase++;
        end

        wait_quiet();
        if (pending_lookups.size() != 0)
            note_mismatch("results never delivered", 64'(pending_lookups.size()), '0);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
